// File: hw/rtl/dle_stx_packet_deframer_assert.svh
// Assertion macros used by the deframer checker RTL.
`ifndef DLE_STX_PACKET_DEFRAMER_ASSERT_SVH
`define DLE_STX_PACKET_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, held off during reset.
`define DLESTX_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define DLESTX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DLESTX_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DLESTX_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/dlestx_pkg.sv
// Types and constants of the DLE/STX packet deframer.
package dlestx_pkg;

  localparam int HEADER_BYTES  = 4;
  localparam int TRAILER_BYTES = 3;
  localparam logic [7:0] FRAME_OVERHEAD = 8'(HEADER_BYTES + TRAILER_BYTES);

  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;
  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] ALT_COMMAND = 8'h01;
  localparam logic [7:0] RESET_MAX_PAYLOAD = 8'd15;
  localparam logic [7:0] LENGTH_CEILING = 8'd248;

  // Configuration register indexes
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_MAX_PAYLOAD      = 1'b0;
  localparam cfg_index_t CFG_EXPECTED_COMMAND = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_STX  = 3'd1,
    PH_CMD  = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_SUM  = 3'd5,
    PH_DLE2 = 3'd6,
    PH_ETX  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_MORE  = 2'd0,
    ST_VALID = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  // Input register contents handed to the frame checker
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_stage_t;

endpackage

// File: hw/rtl/dlestx_if.sv
// Channel interfaces: received bytes in, frame results out.
interface dlestx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dlestx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [7:0] payload_byte;
  logic       payload_strobe;
  logic [7:0] packet_length;

  modport source (output valid, output frame_status, output payload_byte,
                  output payload_strobe, output packet_length, input ready);
  modport sink (input valid, input frame_status, input payload_byte,
                input payload_strobe, input packet_length, output ready);
endinterface

// File: hw/rtl/dlestx_in_stage.sv
// Input register: holds one received byte until the checker takes it.
module dlestx_in_stage (
  input  logic                     clk,
  input  logic                     rst,
  dlestx_in_if.sink                rx,
  input  logic                     take,
  output dlestx_pkg::byte_stage_t  stage
);
  import dlestx_pkg::*;

  // Ready whenever the register is empty or drains this cycle
  assign rx.ready = !stage.valid || take;

  // Occupancy flag with reset; data loads on every accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      stage.valid <= 1'b1;
    end else if (take) begin
      stage.valid <= 1'b0;
    end
    if (rx.valid && rx.ready) begin
      stage.data <= rx.rx_byte;
    end
  end

endmodule

// File: hw/rtl/dlestx_checker.sv
// Frame checker: per-byte phase update, config registers, result register.
`include "dle_stx_packet_deframer_assert.svh"

module dlestx_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  dlestx_pkg::cfg_index_t   cfg_index,
  input  logic [7:0]               cfg_data,
  input  dlestx_pkg::byte_stage_t  stage,
  output logic                     take,
  dlestx_out_if.source             res
);
  import dlestx_pkg::*;

  logic [7:0] max_payload;
  logic [7:0] expected_command;

  phase_t     phase, phase_next;
  logic [7:0] declared_length, declared_length_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] running_xor, running_xor_next;

  status_t    cur_status;
  logic [7:0] cur_pbyte;
  logic       cur_strobe;
  logic [7:0] cur_plen;
  logic       fail;
  logic [7:0] limit;
  logic [7:0] count_inc;
  logic [7:0] b;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload      <= RESET_MAX_PAYLOAD;
      expected_command <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_PAYLOAD:      max_payload <= cfg_data;
        CFG_EXPECTED_COMMAND: expected_command <= cfg_data;
        default: ;
      endcase
    end
  end

  // Move on when the result register is free or being read
  assign take = stage.valid && (!res.valid || res.ready);
  assign b    = stage.data;

  // Next phase and result for the byte in the input register
  always_comb begin
    phase_next           = phase;
    declared_length_next = declared_length;
    payload_count_next   = payload_count;
    running_xor_next     = running_xor;
    cur_status           = ST_MORE;
    cur_pbyte            = 8'd0;
    cur_strobe           = 1'b0;
    cur_plen             = 8'd0;
    fail                 = 1'b0;
    limit     = (max_payload > LENGTH_CEILING) ? LENGTH_CEILING : max_payload;
    count_inc = payload_count + 8'd1;
    case (phase)
      PH_HUNT: begin
        if (b == SYM_DLE) begin
          declared_length_next = 8'd0;
          payload_count_next   = 8'd0;
          running_xor_next     = 8'd0;
          phase_next           = PH_STX;
        end else begin
          fail = 1'b1;
        end
      end
      PH_STX: begin
        if (b == SYM_STX) phase_next = PH_CMD;
        else fail = 1'b1;
      end
      PH_CMD: begin
        if (b == expected_command ||
            (expected_command == 8'd0 && b == ALT_COMMAND)) begin
          phase_next = PH_LEN;
        end else begin
          fail = 1'b1;
        end
      end
      PH_LEN: begin
        if (b > limit) begin
          fail = 1'b1;
        end else begin
          declared_length_next = b;
          payload_count_next   = 8'd0;
          running_xor_next     = 8'd0;
          phase_next           = (b == 8'd0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        cur_pbyte          = b;
        cur_strobe         = 1'b1;
        running_xor_next   = running_xor ^ b;
        payload_count_next = count_inc;
        if (count_inc >= declared_length) phase_next = PH_SUM;
      end
      PH_SUM: begin
        if (b == running_xor) phase_next = PH_DLE2;
        else fail = 1'b1;
      end
      PH_DLE2: begin
        if (b == SYM_DLE) phase_next = PH_ETX;
        else fail = 1'b1;
      end
      PH_ETX: begin
        if (b == SYM_ETX) begin
          cur_status           = ST_VALID;
          cur_plen             = declared_length + FRAME_OVERHEAD;
          declared_length_next = 8'd0;
          payload_count_next   = 8'd0;
          running_xor_next     = 8'd0;
          phase_next           = PH_HUNT;
        end else begin
          fail = 1'b1;
        end
      end
      default: fail = 1'b1;
    endcase
    // Failure: report invalid, recheck the byte as a frame start
    if (fail) begin
      cur_status           = ST_BAD;
      declared_length_next = 8'd0;
      payload_count_next   = 8'd0;
      running_xor_next     = 8'd0;
      phase_next           = (b == SYM_DLE) ? PH_STX : PH_HUNT;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      declared_length <= 8'd0;
      payload_count   <= 8'd0;
      running_xor     <= 8'd0;
    end else if (take) begin
      phase           <= phase_next;
      declared_length <= declared_length_next;
      payload_count   <= payload_count_next;
      running_xor     <= running_xor_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.frame_status   <= cur_status;
      res.payload_byte   <= cur_pbyte;
      res.payload_strobe <= cur_strobe;
      res.packet_length  <= cur_plen;
    end
  end

  // A length only comes with a valid packet
  `DLESTX_ASSERT_IMPLY(a_len_only_valid, clk, rst,
    res.valid && res.frame_status != ST_VALID, res.packet_length == 8'd0)
  // A payload strobe only follows a byte taken in the data phase
  `DLESTX_ASSERT_NEXT(a_strobe_from_data, clk, rst,
    take && phase != PH_DATA, !res.payload_strobe)
  // A completed frame returns the checker to hunting
  `DLESTX_ASSERT_NEXT(a_valid_back_to_hunt, clk, rst,
    take && phase == PH_ETX && b == SYM_ETX, phase == PH_HUNT)
  // A stalled result is not overwritten
  `DLESTX_ASSERT_IMPLY(a_no_overwrite, clk, rst,
    res.valid && !res.ready, !take)

endmodule

// File: hw/rtl/dle_stx_packet_deframer.sv
// Top level of the DLE/STX packet deframer.
//
// Channel rx carries one received byte per transaction (rx_byte). Channel res
// returns exactly one result per byte: frame_status (0 need more, 1 packet
// valid, 2 invalid), payload_byte with payload_strobe for payload bytes, and
// packet_length (total frame bytes) on a valid packet.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 max_payload, 1 expected_command). The user must write only while the
// block is idle; the block itself does not enforce this. An accepted byte
// is registered in the input register, checked there, and its result is
// registered in the result register. Throughput: one byte per cycle while
// res is not stalled; the input register and the result register keep both
// sides moving, and the frame state updates once per byte.
// Reset empties both registers and clears the frame state, returns to
// hunting for DLE, and loads max_payload 15 and expected_command 0.
// When res is stalled the result holds, the input register fills, and rx
// ready drops until the result is taken; no byte is lost.
module dle_stx_packet_deframer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  dlestx_pkg::cfg_index_t  cfg_index,
  input  logic [7:0]              cfg_data,
  dlestx_in_if.sink               rx,
  dlestx_out_if.source            res
);
  import dlestx_pkg::*;

  byte_stage_t stage;
  logic        take;

  dlestx_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .take  (take),
    .stage (stage)
  );

  dlestx_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .take      (take),
    .res       (res)
  );

endmodule
